// ===== src/assert_macros.svh =====
// assertion helpers, clocked on clk and held off during rst
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every edge
`define PSM_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("psm check failed");

// expression must never be true
`define PSM_NEVER(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) \
    else $error("psm check failed");

`endif

// ===== src/psm_pkg.sv =====
`default_nettype none

package psm_pkg;

  localparam int DEPTH     = 512;
  localparam int WORD_BITS = 32;
  localparam int ADDR_BITS = $clog2(DEPTH);
  localparam int PTR_BITS  = 64;
  localparam int DATA_BITS = 32;

  typedef logic [WORD_BITS-1:0] word_t;
  typedef logic [PTR_BITS-1:0]  ptr_t;
  typedef logic [DATA_BITS-1:0] data_t;

  localparam ptr_t TOP     = ptr_t'(DEPTH - 1);
  localparam ptr_t DEPTH_P = ptr_t'(DEPTH);

  // request kinds
  typedef enum logic [1:0] {
    ITEM_LOAD    = 2'd0,
    ITEM_RESTART = 2'd1,
    ITEM_EXEC    = 2'd2,
    ITEM_READ    = 2'd3
  } item_op_t;

  // instruction opcodes
  localparam word_t INS_LIT = word_t'(1);
  localparam word_t INS_OPR = word_t'(2);
  localparam word_t INS_LOD = word_t'(3);
  localparam word_t INS_STO = word_t'(4);
  localparam word_t INS_CAL = word_t'(5);
  localparam word_t INS_INC = word_t'(6);
  localparam word_t INS_JMP = word_t'(7);
  localparam word_t INS_JPC = word_t'(8);
  localparam word_t INS_SYS = word_t'(9);

  // opr codes
  localparam word_t OPR_RTN  = word_t'(0);
  localparam word_t OPR_ADD  = word_t'(1);
  localparam word_t OPR_SUB  = word_t'(2);
  localparam word_t OPR_MUL  = word_t'(3);
  localparam word_t OPR_DIV  = word_t'(4);
  localparam word_t OPR_EQL  = word_t'(5);
  localparam word_t OPR_NEQ  = word_t'(6);
  localparam word_t OPR_LSS  = word_t'(7);
  localparam word_t OPR_LEQ  = word_t'(8);
  localparam word_t OPR_GTR  = word_t'(9);
  localparam word_t OPR_GEQ  = word_t'(10);
  localparam word_t OPR_EVEN = word_t'(11);

  // sys codes
  localparam word_t SYS_OUT  = word_t'(1);
  localparam word_t SYS_READ = word_t'(2);
  localparam word_t SYS_HALT = word_t'(3);

  typedef enum logic [1:0] {
    ERR_NONE     = 2'd0,
    ERR_DIV_ZERO = 2'd1,
    ERR_ADDR     = 2'd2
  } err_t;

  typedef enum logic [4:0] {
    ST_CLEAR, ST_IDLE, ST_LOAD, ST_RD0, ST_RD1,
    ST_F0, ST_F1, ST_F2, ST_F3, ST_DEC,
    ST_RTN1, ST_RTN2, ST_BIN1, ST_BIN2, ST_BIN3, ST_DIVW, ST_BINW,
    ST_EVEN1, ST_JPC1, ST_OUT1,
    ST_WALK, ST_WALK2, ST_LOD1, ST_STO1, ST_CAL2, ST_CAL3,
    ST_DONE
  } st_t;

  function automatic ptr_t sext(input word_t w);
    return ptr_t'($signed(w));
  endfunction

  function automatic logic in_range(input ptr_t a);
    return a < DEPTH_P;
  endfunction

  function automatic word_t data_to_word(input data_t d);
    return word_t'($signed(d));
  endfunction

  function automatic data_t word_to_data(input word_t w);
    return data_t'($signed(w));
  endfunction

endpackage

`default_nettype wire

// ===== src/psm_div.sv =====
`default_nettype none

module psm_div (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  input  wire psm_pkg::word_t dividend,
  input  wire psm_pkg::word_t divisor,
  output logic               done,
  output psm_pkg::word_t     quotient
);
  import psm_pkg::*;

  localparam int CNT_BITS = $clog2(WORD_BITS);

  logic                busy;
  logic [CNT_BITS-1:0] cnt;
  logic                neg;
  word_t               dvs;
  word_t               quo;
  logic [WORD_BITS:0]  rem;
  logic [WORD_BITS:0]  rem_sh;
  logic [WORD_BITS:0]  diff;

  assign rem_sh   = {rem[WORD_BITS-1:0], quo[WORD_BITS-1]};
  assign diff     = rem_sh - {1'b0, dvs};
  assign quotient = neg ? (word_t'(0) - quo) : quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + CNT_BITS'(1);
        if (cnt == CNT_BITS'(WORD_BITS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // restoring division on magnitudes, one quotient bit a cycle
  always_ff @(posedge clk) begin
    if (start) begin
      neg <= dividend[WORD_BITS-1] ^ divisor[WORD_BITS-1];
      quo <= dividend[WORD_BITS-1] ? (word_t'(0) - dividend) : dividend;
      dvs <= divisor[WORD_BITS-1] ? (word_t'(0) - divisor) : divisor;
      rem <= '0;
    end else if (busy) begin
      if (!diff[WORD_BITS]) begin
        rem <= diff;
        quo <= {quo[WORD_BITS-2:0], 1'b1};
      end else begin
        rem <= rem_sh;
        quo <= {quo[WORD_BITS-2:0], 1'b0};
      end
    end
  end

endmodule

`default_nettype wire

// ===== src/pcode_stack_machine_core.sv =====
// channel   | direction | handshake             | payload
// ----------+-----------+-----------------------+------------------------------------
// request   | in        | in_valid / in_ready   | op, address, data
// result    | out       | res_valid / res_ready | halted, error, out_valid, value, ...
// config    | in        | cfg_valid / cfg_ready | program_length
//
// load writes, read reads, restart and a stopped exec go straight to ST_DONE, and an
// instruction fetches op, L, M, walks any static links and runs, a divide waiting on
// the divider (one quotient bit a cycle); every memory access uses the one memory
// after rst a clearing pass zeroes all 512 words, in_ready stays low meanwhile
// a result waits in the output register while the next request is taken; that
// request stalls in its last cycle until res_ready frees the register
`default_nettype none

module pcode_stack_machine_core (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  op,
  input  wire logic [8:0]  address,
  input  wire logic signed [31:0] data,
  output logic             res_valid,
  input  wire logic        res_ready,
  output logic             halted,
  output logic [1:0]       error,
  output logic             out_valid,
  output logic signed [31:0] value,
  output logic             input_taken,
  output logic [3:0]       exec_opcode,
  output logic [7:0]       exec_level,
  output logic signed [31:0] exec_operand,
  output logic [8:0]       pc_now,
  output logic [9:0]       bp_now,
  output logic [9:0]       sp_now,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [9:0]  program_length
);
  import psm_pkg::*;

  // program / stack word memory, one write and one registered read a cycle
  word_t mem [DEPTH];
  word_t ram_q;
  logic  rd_oob_q;

  st_t   state, state_next;
  ptr_t  pc, pc_next, bp, bp_next, sp, sp_next;
  logic  stopped, stopped_next;
  logic [9:0] prog_len;
  logic [ADDR_BITS-1:0] clr_cnt;

  // latched request payload
  logic [8:0] addr_q;
  data_t      data_q;

  // current instruction
  word_t      iop, iop_next, im, im_next;
  logic [7:0] il, il_next;
  ptr_t       imx;

  // static link walk
  ptr_t       walk, walk_next;
  logic [7:0] lvl, lvl_next;

  // operands and result of a binary opr
  word_t a_op, a_next, b_op, b_next, r, r_next;

  logic  err_oob, err_oob_next, err_div, err_div_next;
  logic  ovalid, ovalid_next, taken, taken_next;
  word_t value_q, value_next;

  // memory requests from the sequencer
  logic  rd_en, wr_en;
  ptr_t  rd_addr, wr_addr;
  word_t wr_data;
  ptr_t  mrd;
  logic  oob_hit;

  logic  div_start, div_done;
  word_t div_q;
  logic  res_load;
  logic  accept;
  ptr_t  len_p;

  assign in_ready  = (state == ST_IDLE);
  assign accept    = in_valid && in_ready;
  assign cfg_ready = 1'b1;
  assign imx       = sext(im);
  assign mrd       = rd_oob_q ? '0 : sext(ram_q);
  assign oob_hit   = (rd_en && !in_range(rd_addr)) || (wr_en && !in_range(wr_addr));
  assign len_p     = (ptr_t'(prog_len) > DEPTH_P) ? DEPTH_P : ptr_t'(prog_len);

  psm_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (a_op),
    .divisor  (b_op),
    .done     (div_done),
    .quotient (div_q)
  );

  // memory: clearing pass writes zeros, otherwise in-range writes only
  always_ff @(posedge clk) begin
    if (state == ST_CLEAR) begin
      mem[clr_cnt] <= '0;
    end else if (wr_en && in_range(wr_addr)) begin
      mem[wr_addr[ADDR_BITS-1:0]] <= wr_data;
    end
    ram_q    <= mem[rd_addr[ADDR_BITS-1:0]];
    rd_oob_q <= rd_en && !in_range(rd_addr);
  end

  // sequencer
  always_comb begin
    state_next   = state;
    pc_next      = pc;
    bp_next      = bp;
    sp_next      = sp;
    stopped_next = stopped;
    iop_next     = iop;
    il_next      = il;
    im_next      = im;
    walk_next    = walk;
    lvl_next     = lvl;
    a_next       = a_op;
    b_next       = b_op;
    r_next       = r;
    err_oob_next = err_oob;
    err_div_next = err_div;
    ovalid_next  = ovalid;
    taken_next   = taken;
    value_next   = value_q;
    rd_en        = 1'b0;
    rd_addr      = '0;
    wr_en        = 1'b0;
    wr_addr      = '0;
    wr_data      = '0;
    div_start    = 1'b0;
    res_load     = 1'b0;

    unique case (state)
      ST_CLEAR: begin
        if (clr_cnt == ADDR_BITS'(DEPTH - 1)) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          iop_next     = '0;
          il_next      = '0;
          im_next      = '0;
          err_oob_next = 1'b0;
          err_div_next = 1'b0;
          ovalid_next  = 1'b0;
          taken_next   = 1'b0;
          value_next   = '0;
          unique case (item_op_t'(op))
            ITEM_LOAD:  state_next = ST_LOAD;
            ITEM_READ:  state_next = ST_RD0;
            ITEM_RESTART: begin
              pc_next      = TOP;
              sp_next      = DEPTH_P - len_p;
              bp_next      = DEPTH_P - len_p - ptr_t'(1);
              stopped_next = 1'b0;
              state_next   = ST_DONE;
            end
            ITEM_EXEC: state_next = stopped ? ST_DONE : ST_F0;
            default:   state_next = ST_DONE;
          endcase
        end
      end
      ST_LOAD: begin
        wr_en      = 1'b1;
        wr_addr    = ptr_t'(addr_q);
        wr_data    = data_to_word(data_q);
        state_next = ST_DONE;
      end
      ST_RD0: begin
        rd_en      = 1'b1;
        rd_addr    = ptr_t'(addr_q);
        state_next = ST_RD1;
      end
      ST_RD1: begin
        value_next = mrd[WORD_BITS-1:0];
        state_next = ST_DONE;
      end
      // fetch op, L, M going down from pc
      ST_F0: begin
        rd_en      = 1'b1;
        rd_addr    = pc;
        state_next = ST_F1;
      end
      ST_F1: begin
        iop_next   = mrd[WORD_BITS-1:0];
        rd_en      = 1'b1;
        rd_addr    = pc - ptr_t'(1);
        state_next = ST_F2;
      end
      ST_F2: begin
        il_next    = mrd[7:0];
        rd_en      = 1'b1;
        rd_addr    = pc - ptr_t'(2);
        state_next = ST_F3;
      end
      ST_F3: begin
        im_next    = mrd[WORD_BITS-1:0];
        pc_next    = pc - ptr_t'(3);
        state_next = ST_DEC;
      end
      ST_DEC: begin
        state_next = ST_DONE;
        case (iop)
          INS_LIT: begin
            wr_en   = 1'b1;
            wr_addr = sp - ptr_t'(1);
            wr_data = im;
            sp_next = sp - ptr_t'(1);
          end
          INS_OPR: begin
            if (im == OPR_RTN) begin
              rd_en      = 1'b1;
              rd_addr    = bp - ptr_t'(1);
              sp_next    = bp + ptr_t'(1);
              state_next = ST_RTN1;
            end else if (im >= OPR_ADD && im <= OPR_GEQ) begin
              rd_en      = 1'b1;
              rd_addr    = sp;
              state_next = ST_BIN1;
            end else if (im == OPR_EVEN) begin
              rd_en      = 1'b1;
              rd_addr    = sp;
              state_next = ST_EVEN1;
            end
          end
          INS_LOD, INS_STO, INS_CAL: begin
            walk_next  = bp;
            lvl_next   = il;
            state_next = ST_WALK;
          end
          INS_INC: sp_next = sp - imx;
          INS_JMP: pc_next = TOP - imx;
          INS_JPC: begin
            rd_en      = 1'b1;
            rd_addr    = sp;
            state_next = ST_JPC1;
          end
          INS_SYS: begin
            if (im == SYS_OUT) begin
              rd_en      = 1'b1;
              rd_addr    = sp;
              state_next = ST_OUT1;
            end else if (im == SYS_READ) begin
              wr_en      = 1'b1;
              wr_addr    = sp - ptr_t'(1);
              wr_data    = data_to_word(data_q);
              sp_next    = sp - ptr_t'(1);
              taken_next = 1'b1;
            end else if (im == SYS_HALT) begin
              stopped_next = 1'b1;
            end
          end
          default: ;
        endcase
      end
      // return: sp already bp+1, so sp-3 is the saved pc slot
      ST_RTN1: begin
        bp_next    = mrd;
        rd_en      = 1'b1;
        rd_addr    = sp - ptr_t'(3);
        state_next = ST_RTN2;
      end
      ST_RTN2: begin
        pc_next    = mrd;
        state_next = ST_DONE;
      end
      ST_BIN1: begin
        b_next     = mrd[WORD_BITS-1:0];
        rd_en      = 1'b1;
        rd_addr    = sp + ptr_t'(1);
        state_next = ST_BIN2;
      end
      ST_BIN2: begin
        a_next     = mrd[WORD_BITS-1:0];
        state_next = ST_BIN3;
      end
      ST_BIN3: begin
        state_next = ST_BINW;
        case (im)
          OPR_ADD: r_next = a_op + b_op;
          OPR_SUB: r_next = a_op - b_op;
          OPR_MUL: r_next = a_op * b_op;
          OPR_DIV: begin
            if (b_op == '0) begin
              r_next       = '0;
              err_div_next = 1'b1;
            end else begin
              div_start  = 1'b1;
              state_next = ST_DIVW;
            end
          end
          OPR_EQL: r_next = word_t'(a_op == b_op);
          OPR_NEQ: r_next = word_t'(a_op != b_op);
          OPR_LSS: r_next = word_t'($signed(a_op) < $signed(b_op));
          OPR_LEQ: r_next = word_t'(!($signed(b_op) < $signed(a_op)));
          OPR_GTR: r_next = word_t'($signed(b_op) < $signed(a_op));
          default: r_next = word_t'(!($signed(a_op) < $signed(b_op)));
        endcase
      end
      ST_DIVW: begin
        if (div_done) begin
          r_next     = div_q;
          state_next = ST_BINW;
        end
      end
      ST_BINW: begin
        wr_en      = 1'b1;
        wr_addr    = sp + ptr_t'(1);
        wr_data    = r;
        sp_next    = sp + ptr_t'(1);
        state_next = ST_DONE;
      end
      ST_EVEN1: begin
        wr_en      = 1'b1;
        wr_addr    = sp;
        wr_data    = word_t'(!mrd[0]);
        state_next = ST_DONE;
      end
      ST_JPC1: begin
        if (mrd == '0) begin
          pc_next = TOP - imx;
        end
        sp_next    = sp + ptr_t'(1);
        state_next = ST_DONE;
      end
      ST_OUT1: begin
        value_next  = mrd[WORD_BITS-1:0];
        ovalid_next = 1'b1;
        sp_next     = sp + ptr_t'(1);
        state_next  = ST_DONE;
      end
      // follow static links, reading a link in ST_WALK and taking it in ST_WALK2
      ST_WALK: begin
        if (lvl != 8'd0) begin
          rd_en      = 1'b1;
          rd_addr    = walk;
          state_next = ST_WALK2;
        end else begin
          case (iop)
            INS_LOD: begin
              rd_en      = 1'b1;
              rd_addr    = walk - imx;
              state_next = ST_LOD1;
            end
            INS_STO: begin
              rd_en      = 1'b1;
              rd_addr    = sp;
              state_next = ST_STO1;
            end
            default: begin
              wr_en      = 1'b1;
              wr_addr    = sp - ptr_t'(1);
              wr_data    = walk[WORD_BITS-1:0];
              state_next = ST_CAL2;
            end
          endcase
        end
      end
      ST_WALK2: begin
        walk_next  = mrd;
        lvl_next   = lvl - 8'd1;
        state_next = ST_WALK;
      end
      ST_LOD1: begin
        wr_en      = 1'b1;
        wr_addr    = sp - ptr_t'(1);
        wr_data    = mrd[WORD_BITS-1:0];
        sp_next    = sp - ptr_t'(1);
        state_next = ST_DONE;
      end
      ST_STO1: begin
        wr_en      = 1'b1;
        wr_addr    = walk - imx;
        wr_data    = mrd[WORD_BITS-1:0];
        sp_next    = sp + ptr_t'(1);
        state_next = ST_DONE;
      end
      ST_CAL2: begin
        wr_en      = 1'b1;
        wr_addr    = sp - ptr_t'(2);
        wr_data    = bp[WORD_BITS-1:0];
        state_next = ST_CAL3;
      end
      ST_CAL3: begin
        wr_en      = 1'b1;
        wr_addr    = sp - ptr_t'(3);
        wr_data    = pc[WORD_BITS-1:0];
        bp_next    = sp - ptr_t'(1);
        pc_next    = TOP - imx;
        state_next = ST_DONE;
      end
      ST_DONE: begin
        if (!res_valid || res_ready) begin
          res_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase

    err_oob_next = err_oob_next | oob_hit;
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      clr_cnt   <= '0;
      pc        <= TOP;
      bp        <= TOP;
      sp        <= DEPTH_P;
      stopped   <= 1'b0;
      prog_len  <= '0;
      res_valid <= 1'b0;
    end else begin
      state   <= state_next;
      pc      <= pc_next;
      bp      <= bp_next;
      sp      <= sp_next;
      stopped <= stopped_next;
      if (state == ST_CLEAR) begin
        clr_cnt <= clr_cnt + ADDR_BITS'(1);
      end
      if (cfg_valid && cfg_ready) begin
        prog_len <= program_length;
      end
      if (res_load) begin
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    if (accept) begin
      addr_q <= address;
      data_q <= data;
    end
    iop     <= iop_next;
    il      <= il_next;
    im      <= im_next;
    walk    <= walk_next;
    lvl     <= lvl_next;
    a_op    <= a_next;
    b_op    <= b_next;
    r       <= r_next;
    err_oob <= err_oob_next;
    err_div <= err_div_next;
    ovalid  <= ovalid_next;
    taken   <= taken_next;
    value_q <= value_next;
  end

  // result register
  always_ff @(posedge clk) begin
    if (res_load) begin
      halted       <= stopped;
      error        <= err_oob ? ERR_ADDR : (err_div ? ERR_DIV_ZERO : ERR_NONE);
      out_valid    <= ovalid;
      value        <= word_to_data(value_q);
      input_taken  <= taken;
      exec_opcode  <= iop[3:0];
      exec_level   <= il;
      exec_operand <= word_to_data(im);
      pc_now       <= pc[8:0];
      bp_now       <= bp[9:0];
      sp_now       <= sp[9:0];
    end
  end

endmodule

`default_nettype wire

// ===== src/psm_checker.sv =====
`default_nettype none

`include "assert_macros.svh"

module psm_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_ready,
  input wire logic        res_valid,
  input wire logic        res_ready,
  input wire logic        out_valid,
  input wire logic signed [31:0] value,
  input wire logic        input_taken,
  input wire logic [3:0]  exec_opcode,
  input wire logic signed [31:0] exec_operand
);
  import psm_pkg::*;

  // a stalled result keeps its value
  `PSM_ASSERT(a_res_hold, res_valid && !res_ready |=> res_valid && $stable(value))

  // output values come only from a sys output instruction
  `PSM_ASSERT(a_out_src, res_valid && out_valid |-> exec_opcode == INS_SYS[3:0] && $unsigned(exec_operand) == SYS_OUT)

  // input is consumed only by a sys read instruction
  `PSM_ASSERT(a_take_src, res_valid && input_taken |-> exec_opcode == INS_SYS[3:0] && $unsigned(exec_operand) == SYS_READ)

  // no requests while memory is being cleared after reset
  `PSM_ASSERT(a_clear_busy, $past(rst) |-> !in_ready)

endmodule

bind pcode_stack_machine_core psm_checker u_psm_checker (.*);

`default_nettype wire

// ===== tb/psm_result_checker.sv =====
`timescale 1ns / 100ps
`default_nettype none

module psm_result_checker
  import psm_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  input  wire logic        in_ready,
  input  wire logic [1:0]  op,
  input  wire logic [8:0]  address,
  input  wire logic [31:0] data,
  input  wire logic        res_valid,
  input  wire logic        res_ready,
  input  wire logic        halted,
  input  wire logic [1:0]  error,
  input  wire logic        out_valid,
  input  wire logic [31:0] value,
  input  wire logic        input_taken,
  input  wire logic [3:0]  exec_opcode,
  input  wire logic [7:0]  exec_level,
  input  wire logic [31:0] exec_operand,
  input  wire logic [8:0]  pc_now,
  input  wire logic [9:0]  bp_now,
  input  wire logic [9:0]  sp_now,
  input  wire logic        cfg_valid,
  input  wire logic        cfg_ready,
  input  wire logic [9:0]  program_length,
  output int               fail_count,
  output int               pending
);

  typedef struct packed {
    logic        halted;
    logic [1:0]  error;
    logic        out_valid;
    logic [31:0] value;
    logic        input_taken;
    logic [3:0]  opcode;
    logic [7:0]  level;
    logic [31:0] operand;
    logic [8:0]  pc;
    logic [9:0]  bp;
    logic [9:0]  sp;
  } step_result_t;

  step_result_t results_q[$];

  logic [31:0] mem_words [0:DEPTH-1];
  logic [63:0] pc_m, bp_m, sp_m;
  logic        stopped_m;
  logic [9:0]  length_m;
  err_t        fault;

  function automatic logic [63:0] widen(input logic [31:0] w);
    return {{32{w[31]}}, w};
  endfunction

  function automatic logic [63:0] mem_rd(input logic [63:0] a);
    if (a >= 64'(DEPTH)) begin
      fault = ERR_ADDR;
      return 64'd0;
    end
    return widen(mem_words[a[8:0]]);
  endfunction

  function automatic void mem_wr(input logic [63:0] a, input logic [63:0] v);
    if (a >= 64'(DEPTH)) begin
      fault = ERR_ADDR;
      return;
    end
    mem_words[a[8:0]] = v[31:0];
  endfunction

  function automatic logic [63:0] follow_links(input logic [63:0] start, input logic [7:0] lvl);
    logic [63:0] a;
    a = start;
    for (int i = 0; i < lvl; i++) a = mem_rd(a);
    return a;
  endfunction

  function automatic void arith_op(input logic [63:0] code);
    logic [63:0] a, b, r;
    b = mem_rd(sp_m);
    a = mem_rd(sp_m + 1);
    case (code)
      64'(OPR_ADD): r = a + b;
      64'(OPR_SUB): r = a - b;
      64'(OPR_MUL): r = a * b;
      64'(OPR_DIV): begin
        if (b[31:0] == 32'd0) begin
          if (fault == ERR_NONE) fault = ERR_DIV_ZERO;
          r = 64'd0;
        end else r = $signed(a) / $signed(b);
      end
      64'(OPR_EQL): r = 64'(a == b);
      64'(OPR_NEQ): r = 64'(a != b);
      64'(OPR_LSS): r = 64'($signed(a) < $signed(b));
      64'(OPR_LEQ): r = 64'($signed(a) <= $signed(b));
      64'(OPR_GTR): r = 64'($signed(a) > $signed(b));
      default:      r = 64'($signed(a) >= $signed(b));
    endcase
    mem_wr(sp_m + 1, r);
    sp_m = sp_m + 1;
  endfunction

  function automatic step_result_t predict_step(input logic [1:0] kind,
                                                input logic [8:0] a,
                                                input logic [31:0] d);
    step_result_t res;
    logic [63:0] val, iop, il, im, len, t;
    logic ov, tk;
    val = 0; iop = 0; il = 0; im = 0; ov = 0; tk = 0;
    fault = ERR_NONE;
    case (kind)
      ITEM_LOAD: mem_wr(64'(a), widen(d));
      ITEM_RESTART: begin
        len = (length_m > 10'(DEPTH)) ? 64'(DEPTH) : 64'(length_m);
        pc_m = TOP;
        sp_m = 64'(DEPTH) - len;
        bp_m = sp_m - 1;
        stopped_m = 1'b0;
      end
      ITEM_READ: val = mem_rd(64'(a));
      default: if (!stopped_m) begin
        iop = mem_rd(pc_m);
        il = mem_rd(pc_m - 1);
        im = mem_rd(pc_m - 2);
        pc_m = pc_m - 3;
        case (iop)
          64'(INS_LIT): begin
            sp_m = sp_m - 1;
            mem_wr(sp_m, im);
          end
          64'(INS_OPR): begin
            if (im == 64'(OPR_RTN)) begin
              sp_m = bp_m + 1;
              bp_m = mem_rd(sp_m - 2);
              pc_m = mem_rd(sp_m - 3);
            end else if (im >= 64'(OPR_ADD) && im <= 64'(OPR_GEQ)) arith_op(im);
            else if (im == 64'(OPR_EVEN)) begin
              t = mem_rd(sp_m);
              mem_wr(sp_m, 64'(t[0] == 1'b0));
            end
          end
          64'(INS_LOD): begin
            sp_m = sp_m - 1;
            t = follow_links(bp_m, il[7:0]) - im;
            mem_wr(sp_m, mem_rd(t));
          end
          64'(INS_STO): begin
            t = follow_links(bp_m, il[7:0]) - im;
            mem_wr(t, mem_rd(sp_m));
            sp_m = sp_m + 1;
          end
          64'(INS_CAL): begin
            mem_wr(sp_m - 1, follow_links(bp_m, il[7:0]));
            mem_wr(sp_m - 2, bp_m);
            mem_wr(sp_m - 3, pc_m);
            bp_m = sp_m - 1;
            pc_m = TOP - im;
          end
          64'(INS_INC): sp_m = sp_m - im;
          64'(INS_JMP): pc_m = TOP - im;
          64'(INS_JPC): begin
            t = mem_rd(sp_m);
            if (t[31:0] == 32'd0) pc_m = TOP - im;
            sp_m = sp_m + 1;
          end
          64'(INS_SYS): begin
            if (im == 64'(SYS_OUT)) begin
              val = mem_rd(sp_m);
              ov = 1'b1;
              sp_m = sp_m + 1;
            end else if (im == 64'(SYS_READ)) begin
              sp_m = sp_m - 1;
              mem_wr(sp_m, widen(d));
              tk = 1'b1;
            end else if (im == 64'(SYS_HALT)) stopped_m = 1'b1;
          end
          default: ;
        endcase
      end
    endcase
    res.halted = stopped_m;
    res.error = fault;
    res.out_valid = ov;
    res.value = val[31:0];
    res.input_taken = tk;
    res.opcode = iop[3:0];
    res.level = il[7:0];
    res.operand = im[31:0];
    res.pc = pc_m[8:0];
    res.bp = bp_m[9:0];
    res.sp = sp_m[9:0];
    return res;
  endfunction

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      $display("%0t mismatch %s: expected %h actual %h", $time, name, want, got);
      fail_count++;
    end
  endtask

  step_result_t want;

  always @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < DEPTH; i++) mem_words[i] = 32'd0;
      pc_m = TOP;
      bp_m = TOP;
      sp_m = 64'(DEPTH);
      stopped_m = 1'b0;
      length_m = 10'd0;
      results_q.delete();
      fail_count = 0;
    end else begin
      if (cfg_valid && cfg_ready) length_m = program_length;
      if (res_valid && res_ready) begin
        if (results_q.size() == 0) begin
          $display("%0t unexpected result: expected none actual pc %h", $time, pc_now);
          fail_count++;
        end else begin
          want = results_q.pop_front();
          check_field("halted", 32'(want.halted), 32'(halted));
          check_field("error", 32'(want.error), 32'(error));
          check_field("out_valid", 32'(want.out_valid), 32'(out_valid));
          check_field("value", want.value, value);
          check_field("input_taken", 32'(want.input_taken), 32'(input_taken));
          check_field("exec_opcode", 32'(want.opcode), 32'(exec_opcode));
          check_field("exec_level", 32'(want.level), 32'(exec_level));
          check_field("exec_operand", want.operand, exec_operand);
          check_field("pc_now", 32'(want.pc), 32'(pc_now));
          check_field("bp_now", 32'(want.bp), 32'(bp_now));
          check_field("sp_now", 32'(want.sp), 32'(sp_now));
        end
      end
      if (in_valid && in_ready) results_q.push_back(predict_step(op, address, data));
    end
    pending = results_q.size();
  end

endmodule

`default_nettype wire

// ===== tb/pcode_stack_machine_core_test.sv =====
`timescale 1ns / 100ps
`default_nettype none

module pcode_stack_machine_core_test;
  import psm_pkg::*;

  localparam int REQ_TARGET = 1850;
  localparam int IDLE_LIMIT = 6000;   // a long result hold-off plus a divide fits well inside
  localparam int HOLD_CYCLES = 400;   // long enough to back the block up onto its input
  localparam int DRAIN_CYCLES = 60;   // settling time after the last result

  logic        clk, rst;
  logic        in_valid, in_ready;
  logic [1:0]  op;
  logic [8:0]  address;
  logic [31:0] data;
  logic        res_valid, res_ready;
  logic        halted, out_valid, input_taken;
  logic [1:0]  error;
  logic [31:0] value, exec_operand;
  logic [3:0]  exec_opcode;
  logic [7:0]  exec_level;
  logic [8:0]  pc_now;
  logic [9:0]  bp_now, sp_now;
  logic        cfg_valid, cfg_ready;
  logic [9:0]  program_length;

  int fail_count, pending;
  int req_count;
  int idle_cycles;
  logic quiet;      // sender runs without gaps while set
  logic hold_req;   // asks the receiver for its one long hold-off

  pcode_stack_machine_core uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .op(op), .address(address), .data(data),
    .res_valid(res_valid), .res_ready(res_ready),
    .halted(halted), .error(error), .out_valid(out_valid), .value(value),
    .input_taken(input_taken), .exec_opcode(exec_opcode), .exec_level(exec_level),
    .exec_operand(exec_operand), .pc_now(pc_now), .bp_now(bp_now), .sp_now(sp_now),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .program_length(program_length)
  );

  psm_result_checker u_checker (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .op(op), .address(address), .data(data),
    .res_valid(res_valid), .res_ready(res_ready),
    .halted(halted), .error(error), .out_valid(out_valid), .value(value),
    .input_taken(input_taken), .exec_opcode(exec_opcode), .exec_level(exec_level),
    .exec_operand(exec_operand), .pc_now(pc_now), .bp_now(bp_now), .sp_now(sp_now),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .program_length(program_length),
    .fail_count(fail_count), .pending(pending)
  );

  // 8 ns clock
  initial clk = 1'b0;
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // result side: random stalls, plus one long hold-off on request
  initial begin
    int g;
    logic held;
    res_ready = 1'b0;
    held = 1'b0;
    @(negedge clk);
    forever begin
      if (hold_req && !held) begin
        held = 1'b1;
        res_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      res_ready <= 1'b1;
      repeat (($urandom_range(0, 9) == 0) ? 150 : $urandom_range(1, 20)) @(negedge clk);
      g = pick_gap();
      if (g > 0) begin
        res_ready <= 1'b0;
        repeat (g) @(negedge clk);
      end
    end
  end

  // watchdog: any accepted handshake restarts the count
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (res_valid && res_ready) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else if (idle_cycles >= IDLE_LIMIT) begin
      $display("[pcode_stack_machine_core] ERROR");
      $finish;
    end else
      idle_cycles <= idle_cycles + 1;
  end

  // one request; called at a falling edge, returns at a falling edge
  task automatic send_req(input item_op_t kind, input logic [8:0] a, input logic [31:0] d);
    int g;
    g = quiet ? 0 : pick_gap();
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(negedge clk);
    end
    in_valid <= 1'b1;
    op <= kind;
    address <= a;
    data <= d;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    req_count++;
  endtask

  // drop valid, let every result come back, then let the block settle
  task automatic wait_idle();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_length(input logic [9:0] len);
    wait_idle();
    cfg_valid <= 1'b1;
    program_length <= len;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // instruction k sits at pc = top - 3k as op, L, M
  task automatic load_ins(input int k, input logic [31:0] opc, input logic [31:0] lvl,
                          input logic [31:0] m);
    send_req(ITEM_LOAD, 9'(DEPTH - 1 - 3 * k), opc);
    send_req(ITEM_LOAD, 9'(DEPTH - 2 - 3 * k), lvl);
    send_req(ITEM_LOAD, 9'(DEPTH - 3 - 3 * k), m);
  endtask

  // random instruction, mostly well formed for a program of n instructions
  task automatic random_ins(input int k, input int n);
    int r;
    logic [31:0] opc, lvl, m;
    r = $urandom_range(0, 99);
    if (r < 15)      opc = INS_LIT;
    else if (r < 40) opc = INS_OPR;
    else if (r < 50) opc = INS_LOD;
    else if (r < 60) opc = INS_STO;
    else if (r < 65) opc = INS_CAL;
    else if (r < 73) opc = INS_INC;
    else if (r < 78) opc = INS_JMP;
    else if (r < 86) opc = INS_JPC;
    else if (r < 96) opc = INS_SYS;
    else opc = ($urandom_range(0, 1) != 0) ? $urandom : 32'($urandom_range(10, 15));
    r = $urandom_range(0, 99);
    lvl = (r < 80) ? 32'd0 : (r < 95) ? 32'($urandom_range(1, 2)) : $urandom;
    r = $urandom_range(0, 99);
    case (opc)
      INS_LIT: m = (r < 50) ? 32'($urandom_range(0, 20)) : $urandom;
      INS_OPR: m = (r < 92) ? 32'($urandom_range(0, 11)) : $urandom;
      INS_LOD, INS_STO: m = (r < 92) ? 32'($urandom_range(0, 4)) : $urandom;
      INS_INC: m = (r < 80) ? 32'($urandom_range(0, 5)) : -32'($urandom_range(1, 3));
      INS_CAL, INS_JMP, INS_JPC: m = (r < 92) ? 32'(3 * $urandom_range(0, n - 1)) : $urandom;
      INS_SYS: m = (r < 45) ? SYS_OUT : (r < 80) ? SYS_READ : (r < 92) ? SYS_HALT : $urandom;
      default: m = $urandom;
    endcase
    load_ins(k, opc, lvl, m);
  endtask

  // one program: length, load, restart, then mostly steps with some noise
  task automatic run_program();
    int n, steps, r;
    logic [9:0] len;
    n = ($urandom_range(0, 99) < 4) ? $urandom_range(100, 170) : $urandom_range(2, 12);
    r = $urandom_range(0, 99);
    if (r < 85) len = 10'(3 * n);
    else if (r < 90) len = 10'd0;
    else if (r < 95) len = 10'(DEPTH);
    else len = 10'($urandom_range(0, DEPTH));
    write_length(len);
    quiet = ($urandom_range(0, 3) == 0);
    for (int k = 0; k < n; k++) random_ins(k, n);
    send_req(ITEM_RESTART, 9'($urandom), $urandom);
    steps = $urandom_range(15, 60);
    for (int s = 0; s < steps; s++) begin
      r = $urandom_range(0, 99);
      if (r < 82)      send_req(ITEM_EXEC, 9'($urandom), $urandom);
      else if (r < 90) send_req(ITEM_READ, 9'($urandom_range(0, DEPTH - 1)), $urandom);
      else if (r < 96) send_req(ITEM_LOAD, 9'($urandom_range(0, DEPTH - 1)), $urandom);
      else             send_req(ITEM_RESTART, 9'($urandom), $urandom);
    end
  endtask

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    op = ITEM_LOAD;
    address = 9'd0;
    data = 32'd0;
    cfg_valid = 1'b0;
    program_length = 10'd0;
    quiet = 1'b0;
    hold_req = 1'b0;
    req_count = 0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // zeroed memory: unknown opcode, extreme addresses and words
    write_length(10'd0);
    send_req(ITEM_EXEC, 9'd0, 32'd0);
    send_req(ITEM_LOAD, 9'd0, 32'h8000_0000);
    send_req(ITEM_READ, 9'd0, 32'hffff_ffff);
    send_req(ITEM_READ, 9'd300, 32'h0);

    // min / -1 wraps, then output, halt, and a step while stopped
    load_ins(0, INS_LIT, 32'd0, 32'h8000_0000);
    load_ins(1, INS_LIT, 32'hffff_ffff, 32'hffff_ffff);
    load_ins(2, INS_OPR, 32'd0, OPR_DIV);
    load_ins(3, INS_SYS, 32'd0, SYS_OUT);
    load_ins(4, INS_SYS, 32'd0, SYS_HALT);
    write_length(10'd15);
    send_req(ITEM_RESTART, 9'h1ff, 32'h7fff_ffff);
    repeat (6) send_req(ITEM_EXEC, 9'h1ff, 32'h7fff_ffff);
    send_req(ITEM_READ, 9'h1ff, 32'd0);
    write_length(10'(DEPTH));
    send_req(ITEM_RESTART, 9'd0, 32'd0);

    // random programs; the long result hold-off lands in the middle
    while (req_count < REQ_TARGET) begin
      if (req_count > REQ_TARGET / 2 && !hold_req) begin
        quiet = 1'b1;
        hold_req = 1'b1;
      end
      run_program();
    end

    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0)
      $display("[pcode_stack_machine_core] OK");
    else
      $display("[pcode_stack_machine_core] ERROR");
    $finish;
  end

endmodule

`default_nettype wire
